// ===== hdl/dcsm_pkg.sv =====
`timescale 1ns / 1ps
package dcsm_pkg;

   localparam int unsigned TOP_BIN_DEFAULT = 4095;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned TAB_W    = 4;
   localparam int unsigned VALUE_W  = 24;
   localparam int unsigned COUNT_W  = 40;
   localparam int unsigned SUM_W    = 64;
   localparam int unsigned MEDIAN_W = 12;

   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [TAB_W-1:0] COLUMN_SELECT_RESET = TAB_W'(2);
   localparam logic [TAB_W-1:0] TAB_COUNT_MAX       = '1;
   localparam logic [VALUE_W-1:0] VALUE_MAX         = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX         = '1;

   localparam logic FUNC_FEED   = 1'b0;
   localparam logic FUNC_REPORT = 1'b1;

   localparam logic [BYTE_W-1:0] CHAR_TAB     = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_VTAB    = 8'h0B;
   localparam logic [BYTE_W-1:0] CHAR_FFEED   = 8'h0C;
   localparam logic [BYTE_W-1:0] CHAR_CR      = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_PLUS    = 8'h2B;
   localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE    = 8'h39;

   typedef enum logic [1:0] {
      PHASE_BEFORE,
      PHASE_DIGITS,
      PHASE_DONE
   } phase_type;

   typedef enum logic {
      CMD_LINE,
      CMD_REPORT
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type         kind;
      logic [VALUE_W-1:0]   value;
   } cmd_type;

   typedef enum logic [2:0] {
      BACK_CLEAR,
      BACK_IDLE,
      BACK_LINE_UPDATE,
      BACK_LINE_SQUARE,
      BACK_WALK,
      BACK_REPORT
   } back_state_type;

endpackage

// ===== hdl/dcsm_if.sv =====
`timescale 1ns / 1ps
interface dcsm_req_if;
   logic                          valid;
   logic                          ready;
   logic                          func;
   logic [dcsm_pkg::BYTE_W-1:0]   data_byte;

   modport source (output valid, output func, output data_byte, input ready);
   modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface dcsm_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [dcsm_pkg::COUNT_W-1:0]    line_count;
   logic [dcsm_pkg::SUM_W-1:0]      value_sum;
   logic [dcsm_pkg::SUM_W-1:0]      value_square_sum;
   logic [dcsm_pkg::VALUE_W-1:0]    max_value;
   logic [dcsm_pkg::MEDIAN_W-1:0]   median_bin;

   modport source (output valid, output line_count, output value_sum,
                   output value_square_sum, output max_value, output median_bin,
                   input ready);
   modport sink   (input valid, input line_count, input value_sum,
                   input value_square_sum, input max_value, input median_bin,
                   output ready);
endinterface

interface dcsm_csr_if;
   logic                         valid;
   logic                         ready;
   logic [dcsm_pkg::TAB_W-1:0]   column_select;

   modport source (output valid, output column_select, input ready);
   modport sink   (input valid, input column_select, output ready);
endinterface

// ===== hdl/dcsm_front.sv =====
`timescale 1ns / 1ps
module dcsm_front (
   input  logic              clock,
   input  logic              reset,
   dcsm_req_if.sink          req_bus,
   dcsm_csr_if.sink          csr_bus,
   input  logic              clearing,
   input  logic              queue_full,
   output logic              push,
   output dcsm_pkg::cmd_type push_cmd
);
   import dcsm_pkg::*;

   logic [TAB_W-1:0]   column_select_ff;
   logic [TAB_W-1:0]   tab_count_ff, tab_count_in;
   phase_type          phase_ff, phase_in;
   logic [VALUE_W-1:0] value_ff, value_in;

   logic               accept;
   logic [BYTE_W-1:0]  b;
   logic               is_digit, is_space, selected;
   logic [VALUE_W+3:0] times_ten;

   assign req_bus.ready = !clearing && !queue_full;
   assign csr_bus.ready = 1'b1;
   assign accept        = req_bus.valid && req_bus.ready;
   assign b             = req_bus.data_byte;

   always_comb begin
      is_digit  = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
      is_space  = (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_VTAB) ||
                  (b == CHAR_FFEED) || (b == CHAR_CR);
      selected  = (tab_count_ff == column_select_ff);
      // value * 10 + digit, as two shifts and two adds
      times_ten = ({4'b0, value_ff} << 3) + ({4'b0, value_ff} << 1) +
                  (VALUE_W+4)'(b - CHAR_ZERO);
   end

   always_comb begin
      tab_count_in = tab_count_ff;
      phase_in     = phase_ff;
      value_in     = value_ff;
      push         = 1'b0;
      push_cmd     = '{kind: CMD_LINE, value: value_ff};
      if (accept && req_bus.func == FUNC_FEED) begin
         if (selected && phase_ff != PHASE_DONE) begin
            priority if (is_digit) begin
               value_in = (|times_ten[VALUE_W+3:VALUE_W]) ? VALUE_MAX
                                                          : times_ten[VALUE_W-1:0];
               phase_in = PHASE_DIGITS;
            end else if (phase_ff == PHASE_BEFORE && is_space) begin
               phase_in = phase_ff;
            end else if (phase_ff == PHASE_BEFORE && b == CHAR_PLUS) begin
               phase_in = PHASE_DIGITS;
            end else begin
               phase_in = PHASE_DONE;
            end
         end
         if (selected && b == CHAR_TAB) begin
            phase_in = PHASE_DONE;
         end
         if (b == CHAR_NEWLINE) begin
            push         = 1'b1;
            push_cmd     = '{kind: CMD_LINE, value: value_in};
            tab_count_in = '0;
            phase_in     = PHASE_BEFORE;
            value_in     = '0;
         end else if (b == CHAR_TAB && tab_count_ff != TAB_COUNT_MAX) begin
            tab_count_in = tab_count_ff + 1'b1;
         end
      end else if (accept) begin
         push     = 1'b1;
         push_cmd = '{kind: CMD_REPORT, value: '0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_select_ff <= COLUMN_SELECT_RESET;
         tab_count_ff     <= '0;
         phase_ff         <= PHASE_BEFORE;
         value_ff         <= '0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            column_select_ff <= csr_bus.column_select;
         end
         tab_count_ff <= tab_count_in;
         phase_ff     <= phase_in;
         value_ff     <= value_in;
      end
   end

endmodule

// ===== hdl/dcsm_queue.sv =====
`timescale 1ns / 1ps
module dcsm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dcsm_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output dcsm_pkg::cmd_type head_cmd,
   output logic              empty
);
   import dcsm_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hdl/dcsm_back.sv =====
`timescale 1ns / 1ps
module dcsm_back #(
   parameter int unsigned TOP_BIN = dcsm_pkg::TOP_BIN_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  dcsm_pkg::cmd_type head_cmd,
   input  logic              queue_empty,
   output logic              pop,
   output logic              clearing,
   dcsm_rsp_if.source        rsp_bus
);
   import dcsm_pkg::*;

   localparam int unsigned BIN_W = (TOP_BIN < 2) ? 1 : $clog2(TOP_BIN + 1);
   localparam int unsigned RUN_W = COUNT_W + BIN_W;
   localparam logic [BIN_W-1:0] TOP_ADDR = BIN_W'(TOP_BIN);

   back_state_type      state_ff, state_in;

   logic [COUNT_W-1:0]  bins_mem [TOP_BIN+1];
   logic [COUNT_W-1:0]  rd_data_ff;
   logic                rd_en, wr_en;
   logic [BIN_W-1:0]    rd_addr, wr_addr;
   logic [COUNT_W-1:0]  wr_data;

   logic [BIN_W-1:0]    clear_addr_ff;
   logic [VALUE_W-1:0]  line_value_ff;
   logic [BIN_W-1:0]    line_bin_ff;
   logic [2*VALUE_W-1:0] square_ff;

   logic [COUNT_W-1:0]  lines_ff;
   logic [SUM_W-1:0]    sum_ff, square_sum_ff;
   logic [VALUE_W-1:0]  max_ff;

   logic [BIN_W-1:0]    pend_idx_ff;
   logic [RUN_W-1:0]    run_ff, run_new;
   logic [BIN_W-1:0]    median_ff;
   logic                found, walk_stop;

   logic                rsp_valid_ff, load_rsp;
   logic [COUNT_W-1:0]  rsp_lines_ff;
   logic [SUM_W-1:0]    rsp_sum_ff, rsp_square_sum_ff;
   logic [VALUE_W-1:0]  rsp_max_ff;
   logic [BIN_W-1:0]    rsp_median_ff;

   logic [BIN_W-1:0]    head_bin;

   assign clearing = (state_ff == BACK_CLEAR);
   assign head_bin = (head_cmd.value >= VALUE_W'(TOP_BIN)) ? TOP_ADDR
                                                           : head_cmd.value[BIN_W-1:0];

   // walk step: running count against half the line count
   always_comb begin
      run_new   = run_ff + RUN_W'(rd_data_ff);
      found     = {run_new, 1'b0} > (RUN_W+1)'(lines_ff);
      walk_stop = found || (pend_idx_ff == TOP_ADDR);
   end

   assign load_rsp = (state_ff == BACK_REPORT) && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_CLEAR: begin
            if (clear_addr_ff == TOP_ADDR) state_in = BACK_IDLE;
         end
         BACK_IDLE: begin
            if (!queue_empty) begin
               state_in = (head_cmd.kind == CMD_LINE) ? BACK_LINE_UPDATE : BACK_WALK;
            end
         end
         BACK_LINE_UPDATE: state_in = BACK_LINE_SQUARE;
         BACK_LINE_SQUARE: state_in = BACK_IDLE;
         BACK_WALK: begin
            if (walk_stop) state_in = BACK_REPORT;
         end
         BACK_REPORT: begin
            if (load_rsp) state_in = BACK_IDLE;
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = clear_addr_ff;
      wr_data = '0;
      pop     = 1'b0;
      unique case (state_ff)
         BACK_CLEAR: wr_en = 1'b1;
         BACK_IDLE: begin
            if (!queue_empty) begin
               pop     = 1'b1;
               rd_en   = 1'b1;
               rd_addr = (head_cmd.kind == CMD_LINE) ? head_bin : '0;
            end
         end
         BACK_LINE_UPDATE: begin
            wr_en   = 1'b1;
            wr_addr = line_bin_ff;
            wr_data = (rd_data_ff == COUNT_MAX) ? rd_data_ff : rd_data_ff + 1'b1;
         end
         BACK_LINE_SQUARE: ;
         BACK_WALK: begin
            rd_en   = !walk_stop;
            rd_addr = pend_idx_ff + 1'b1;
         end
         BACK_REPORT: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bins_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= bins_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BACK_CLEAR;
         clear_addr_ff <= '0;
         lines_ff      <= '0;
         sum_ff        <= '0;
         square_sum_ff <= '0;
         max_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == BACK_CLEAR) begin
            clear_addr_ff <= clear_addr_ff + 1'b1;
         end
         if (state_ff == BACK_LINE_UPDATE) begin
            if (lines_ff != COUNT_MAX) lines_ff <= lines_ff + 1'b1;
            sum_ff <= sum_ff + SUM_W'(line_value_ff);
            if (line_value_ff > max_ff) max_ff <= line_value_ff;
         end
         if (state_ff == BACK_LINE_SQUARE) begin
            square_sum_ff <= square_sum_ff + SUM_W'(square_ff);
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == BACK_IDLE && !queue_empty) begin
         line_value_ff <= head_cmd.value;
         line_bin_ff   <= head_bin;
         pend_idx_ff   <= '0;
         run_ff        <= '0;
      end
      if (state_ff == BACK_LINE_UPDATE) begin
         square_ff <= line_value_ff * line_value_ff;
      end
      if (state_ff == BACK_WALK) begin
         run_ff      <= run_new;
         pend_idx_ff <= pend_idx_ff + 1'b1;
         if (walk_stop) median_ff <= found ? pend_idx_ff : '0;
      end
      if (load_rsp) begin
         rsp_lines_ff      <= lines_ff;
         rsp_sum_ff        <= sum_ff;
         rsp_square_sum_ff <= square_sum_ff;
         rsp_max_ff        <= max_ff;
         rsp_median_ff     <= median_ff;
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.line_count       = rsp_lines_ff;
   assign rsp_bus.value_sum        = rsp_sum_ff;
   assign rsp_bus.value_square_sum = rsp_square_sum_ff;
   assign rsp_bus.max_value        = rsp_max_ff;
   assign rsp_bus.median_bin       = MEDIAN_W'(rsp_median_ff);

endmodule

// ===== hdl/depth_column_stats_median.sv =====
`timescale 1ns / 1ps
// streaming column statistics over tab-separated text
// req channel: one beat per text byte (func feed) or one report request (func report)
// rsp channel: one beat per report with line count, value sum, square sum, max and
//   median bin; fed bytes give no beat
// csr channel: one beat writes column_select (tabs before the parsed column), always ready
// throughput: the parser takes one byte per cycle while the command queue has room and no clearing pass runs
// each newline takes the back end through a histogram read, a write back and a square add;
//   a steady stream of very short lines fills the queue and stalls req
// report path with the queue empty: the req beat is queued and popped by the back end,
//   which walks the histogram memory, one bin read per cycle, up to the last bin walked
//   (the median bin, or TOP_BIN when no bin qualifies) and then loads the output
//   register that raises rsp valid
// reset: the histogram memory is cleared by a pass over all TOP_BIN + 1 bins, one bin
//   per cycle, during which req is not ready; csr writes are taken as ever
// a stalled rsp holds its beat in the output register; the back end parks the next
//   report until that register frees, while the parser keeps taking bytes until the
//   queue fills
module depth_column_stats_median #(
   parameter int unsigned TOP_BIN = dcsm_pkg::TOP_BIN_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   dcsm_req_if.sink     req_bus,
   dcsm_rsp_if.source   rsp_bus,
   dcsm_csr_if.sink     csr_bus
);
   import dcsm_pkg::*;

   // command path from parser to statistics engine
   logic    push, pop;
   cmd_type push_cmd, head_cmd;
   logic    queue_full, queue_empty;
   // histogram clearing pass still running
   logic    clearing;

   // front end: tab counting, atoi-style parse of the chosen column
   dcsm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .csr_bus    (csr_bus),
      .clearing   (clearing),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   // short queue of line-end and report commands
   dcsm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (queue_empty)
   );

   // back end: histogram memory, sums, max, median walk and output register
   dcsm_back #(
      .TOP_BIN (TOP_BIN)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_cmd    (head_cmd),
      .queue_empty (queue_empty),
      .pop         (pop),
      .clearing    (clearing),
      .rsp_bus     (rsp_bus)
   );

endmodule
